// ===== hw/rtl/i2c_bridge_request_framer_defines.svh =====
// Assertion macros shared by the framer's checker.
`ifndef I2C_BRIDGE_REQUEST_FRAMER_DEFINES_SVH
`define I2C_BRIDGE_REQUEST_FRAMER_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define I2CBRF_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define I2CBRF_ASSERT_CLK(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/i2cbrf_pkg.sv =====
// Types and codes of the I2C bridge request framer.
package i2cbrf_pkg;

	// command codes
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_DATA  = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_BAD_LEN = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;
	localparam logic [1:0] STATUS_SEQ     = 2'd3;

	// frame bytes
	localparam logic [7:0] BYTE_STX   = 8'h02;
	localparam logic [7:0] BYTE_ETX   = 8'h03;
	localparam logic [7:0] BYTE_FUNC  = 8'h03;
	localparam logic [7:0] BYTE_READ  = 8'h52;
	localparam logic [7:0] BYTE_WRITE = 8'h57;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_WIDTH     = 1'b1;

	localparam logic [2:0] ADDR_WIDTH_MAX   = 3'd4;
	localparam logic [2:0] ADDR_WIDTH_RESET = 3'd1;

	typedef struct packed {
		logic [1:0]  command;
		logic [8:0]  length;
		logic [31:0] offset;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last;
		logic [1:0] status;
	} out_item_t;

endpackage

// ===== hw/rtl/i2c_bridge_request_framer.sv =====
// I2C bridge request framer: start/data transactions in, frame bytes out.
// The first result passes stage 1 and the output register. Throughput: one
//   result per cycle unless out_stall holds it; a transaction has 1 to 14 results,
//   set by the byte sequencer in stage 1; the next one waits for its last to advance.
// Reset (arst_n low, asynchronous): idle, no write pending, device_address 0,
//   addr_width 1.
module i2c_bridge_request_framer #(
	parameter int FRAME_BYTES       = 256,
	parameter int RESP_HEADER_BYTES = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  i2cbrf_pkg::in_item_t           in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output i2cbrf_pkg::out_item_t          out_data,
	input  logic                           cfg_we,
	input  logic [i2cbrf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_wdata
);
	import i2cbrf_pkg::*;

	localparam logic [16:0] FRAME_LIM = 17'(FRAME_BYTES);
	localparam logic [16:0] RESP_HDR  = 17'(RESP_HEADER_BYTES);

	// what stage 1 holds
	localparam logic [1:0] KIND_ERR   = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_FRAME = 2'd2;

	// configuration
	logic [7:0] device_address_q;
	logic [2:0] addr_width_q;

	// sequence state, updated as each transaction is accepted
	logic       write_pending_q;
	logic [8:0] bytes_remaining_q;

	// stage 1: the accepted transaction, decoded
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [1:0]  status_s1;
	logic [3:0]  cnt_s1;      // index of the final result
	logic        is_write_s1;
	logic [7:0]  dev_s1;
	logic [2:0]  aw_s1;
	logic [15:0] msg_len_s1;
	logic [8:0]  len_s1;
	logic [31:0] offset_s1;
	logic [7:0]  data_s1;
	logic [3:0]  idx_q;       // result being produced

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	logic in_acc;
	logic adv;
	logic at_last;

	// decode of the incoming transaction
	logic [2:0]  aw;
	logic [15:0] msg_len;
	logic        rd_too_long;
	logic        msg_too_long;
	logic [8:0]  rem_dec;
	logic [1:0]  kind_d;
	logic [1:0]  status_d;
	logic [3:0]  cnt_d;
	logic        pend_d;
	logic [8:0]  rem_d;

	// byte selection for the current index
	logic [3:0] k;
	logic [3:0] m;
	logic [1:0] sel;
	logic [7:0] off_byte;
	logic [7:0] byte_d;

	assign adv      = !out_valid_q || !out_stall;
	assign at_last  = (idx_q == cnt_s1);
	assign in_stall = valid_s1 && !(adv && at_last);
	assign in_acc   = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		aw           = (addr_width_q > ADDR_WIDTH_MAX) ? ADDR_WIDTH_MAX : addr_width_q;
		msg_len      = 16'd7 + {13'b0, aw} + {7'b0, in_data.length};
		rd_too_long  = ({8'b0, in_data.length} + RESP_HDR) > FRAME_LIM;
		msg_too_long = {1'b0, msg_len} > FRAME_LIM;
		rem_dec      = bytes_remaining_q - 9'd1;
		kind_d       = KIND_ERR;
		status_d     = STATUS_OK;
		cnt_d        = 4'd0;
		pend_d       = write_pending_q;
		rem_d        = bytes_remaining_q;
		unique case (in_data.command)
			CMD_DATA: begin
				if (!write_pending_q) begin
					// data with no write open: flagged, state untouched
					status_d = STATUS_SEQ;
				end else begin
					kind_d = KIND_DATA;
					rem_d  = rem_dec;
					if (rem_dec == 9'd0) begin
						// last data byte: ETX follows
						pend_d = 1'b0;
						cnt_d  = 4'd1;
					end
				end
			end
			CMD_READ, CMD_WRITE: begin
				// any start abandons an open write frame
				pend_d = 1'b0;
				rem_d  = 9'd0;
				priority if (in_data.command == CMD_WRITE && in_data.length == 9'd0) begin
					status_d = STATUS_BAD_LEN;
				end else if (in_data.command == CMD_READ && rd_too_long) begin
					status_d = STATUS_BAD_LEN;
				end else if (msg_too_long) begin
					status_d = STATUS_TOO_LONG;
				end else begin
					kind_d = KIND_FRAME;
					if (in_data.command == CMD_WRITE) begin
						cnt_d  = 4'd8 + {1'b0, aw};
						pend_d = 1'b1;
						rem_d  = in_data.length;
					end else begin
						cnt_d = 4'd9 + {1'b0, aw};
					end
				end
			end
			default: begin
				// unused code: no results, nothing changes
			end
		endcase
	end

	// frame layout: STX, len hi, len lo, FUNC, dev, aw, offset bytes,
	// R/W, count hi, count lo, then ETX for reads
	always_comb begin
		k   = idx_q - 4'd6;
		m   = k - {1'b0, aw_s1};
		sel = aw_s1[1:0] - 2'd1 - k[1:0];
		unique case (sel)
			2'd0: off_byte = offset_s1[7:0];
			2'd1: off_byte = offset_s1[15:8];
			2'd2: off_byte = offset_s1[23:16];
			default: off_byte = offset_s1[31:24];
		endcase
		byte_d = 8'h00;
		unique case (kind_s1)
			KIND_DATA: begin
				byte_d = (idx_q == 4'd0) ? data_s1 : BYTE_ETX;
			end
			KIND_FRAME: begin
				priority if (idx_q == 4'd0) begin
					byte_d = BYTE_STX;
				end else if (idx_q == 4'd1) begin
					byte_d = msg_len_s1[15:8];
				end else if (idx_q == 4'd2) begin
					byte_d = msg_len_s1[7:0];
				end else if (idx_q == 4'd3) begin
					byte_d = BYTE_FUNC;
				end else if (idx_q == 4'd4) begin
					byte_d = dev_s1;
				end else if (idx_q == 4'd5) begin
					byte_d = {5'b0, aw_s1};
				end else if (k < {1'b0, aw_s1}) begin
					byte_d = off_byte;
				end else if (m == 4'd0) begin
					byte_d = is_write_s1 ? BYTE_WRITE : BYTE_READ;
				end else if (m == 4'd1) begin
					byte_d = {7'b0, len_s1[8]};
				end else if (m == 4'd2) begin
					byte_d = len_s1[7:0];
				end else begin
					byte_d = BYTE_ETX;
				end
			end
			default: byte_d = 8'h00;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= 8'h00;
			addr_width_q     <= ADDR_WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEVICE_ADDRESS: device_address_q <= cfg_wdata;
				REG_ADDR_WIDTH:     addr_width_q     <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// sequence state and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pending_q   <= 1'b0;
			bytes_remaining_q <= 9'd0;
			valid_s1          <= 1'b0;
			idx_q             <= 4'd0;
		end else begin
			if (in_acc) begin
				write_pending_q   <= pend_d;
				bytes_remaining_q <= rem_d;
			end
			if (in_acc && in_data.command != CMD_NONE) begin
				valid_s1 <= 1'b1;
				idx_q    <= 4'd0;
			end else if (valid_s1 && adv) begin
				if (at_last) begin
					valid_s1 <= 1'b0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1     <= kind_d;
			status_s1   <= status_d;
			cnt_s1      <= cnt_d;
			is_write_s1 <= (in_data.command == CMD_WRITE);
			dev_s1      <= device_address_q;
			aw_s1       <= aw;
			msg_len_s1  <= msg_len;
			len_s1      <= in_data.length;
			offset_s1   <= in_data.offset;
			data_s1     <= in_data.data_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.frame_byte <= byte_d;
			out_q.last       <= at_last;
			out_q.status     <= status_s1;
		end
	end

endmodule

// ===== hw/rtl/i2cbrf_checker.sv =====
// Port-level checks for the I2C bridge request framer, bound to the top level.
`include "i2c_bridge_request_framer_defines.svh"

module i2cbrf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input i2cbrf_pkg::out_item_t            out_data
);
	import i2cbrf_pkg::*;

	`I2CBRF_ASSERT_RST(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "stalled result changed")
	`I2CBRF_ASSERT_RST(a_err_last, clk, arst_n, (out_valid && out_data.status != STATUS_OK) |-> out_data.last, "error result not marked last")
	`I2CBRF_ASSERT_RST(a_err_zero, clk, arst_n, (out_valid && out_data.status != STATUS_OK) |-> (out_data.frame_byte == 8'h00), "error result carries a byte")
	`I2CBRF_ASSERT_RST(a_run_on, clk, arst_n, (out_valid && !out_stall && !out_data.last) |=> out_valid, "gap inside a result run")

endmodule

bind i2c_bridge_request_framer i2cbrf_checker u_i2cbrf_checker (.*);

// ===== tb/i2c_bridge_request_framer_tb.sv =====
// Self-checking testbench of the I2C bridge request framer, with a built-in frame predictor.
`timescale 1ns / 1ps

module i2c_bridge_request_framer_tb;
	import i2cbrf_pkg::*;

	localparam int FRAME_BYTES       = 256;
	localparam int RESP_HEADER_BYTES = 2;
	// bytes of the message length that do not depend on offset width or data count
	localparam int MSG_FIXED_BYTES   = 7;

	localparam int CLK_HALF_NS   = 4;
	localparam int RESET_CYCLES  = 6;
	// first result passes stage 1 and the output register; leave plenty of slack
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_CYCLES    = 1000000;
	localparam int RANDOM_ITEMS  = 110;
	localparam int LONG_WRITE_LEN = 64;
	localparam int MAX_PRINTED   = 40;

	// receiver stall patterns
	typedef enum int {RX_FREE, RX_SCATTER, RX_BURSTY} rx_mode_e;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [7:0]            cfg_wdata;

	i2c_bridge_request_framer #(
		.FRAME_BYTES       (FRAME_BYTES),
		.RESP_HEADER_BYTES (RESP_HEADER_BYTES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor state: its own copy of the registers and of the write sequencing.
	logic [7:0] pred_dev_addr;
	logic [2:0] pred_addr_width;
	logic       pred_write_open;
	logic [8:0] pred_bytes_left;

	// Frame bytes predicted but not yet seen on the output, oldest first.
	out_item_t  frame_q[$];

	int unsigned n_items       = 0;
	int unsigned n_ignored     = 0;
	int unsigned n_frames      = 0;
	int unsigned n_err_results = 0;
	int unsigned n_checked     = 0;
	int unsigned n_mismatch    = 0;
	int unsigned cycle_count   = 0;
	int          burst_left    = 0;

	rx_mode_e    rx_mode       = RX_FREE;
	int          rx_mode_left  = 0;
	int          rx_run        = 0;
	out_item_t   want_res;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF_NS clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Frame predictor
	// ------------------------------------------------------------------
	function automatic void expect_byte(input logic [7:0] b, input logic l,
		input logic [1:0] s);
		out_item_t r;
		r.frame_byte = b;
		r.last       = l;
		r.status     = s;
		frame_q.push_back(r);
	endfunction

	// Works out every frame byte one accepted transaction causes.
	function automatic void predict_frame(input in_item_t it);
		logic [2:0]  aw;
		int unsigned msg_len;
		logic        is_wr;
		case (it.command)
			CMD_NONE: begin
				// unused code: nothing out, state untouched
			end
			CMD_DATA: begin
				if (!pred_write_open) begin
					// data with no write frame open
					expect_byte(8'h00, 1'b1, STATUS_SEQ);
					n_err_results++;
				end else begin
					pred_bytes_left = pred_bytes_left - 9'd1;
					if (pred_bytes_left == 9'd0) begin
						// last data byte closes the frame with ETX
						pred_write_open = 1'b0;
						expect_byte(it.data_byte, 1'b0, STATUS_OK);
						expect_byte(BYTE_ETX, 1'b1, STATUS_OK);
					end else begin
						expect_byte(it.data_byte, 1'b1, STATUS_OK);
					end
				end
			end
			default: begin
				// any start drops a write frame still waiting for data
				pred_write_open = 1'b0;
				pred_bytes_left = '0;
				is_wr   = (it.command == CMD_WRITE);
				// widths above the maximum are clamped everywhere
				aw      = (pred_addr_width > ADDR_WIDTH_MAX) ? ADDR_WIDTH_MAX
					: pred_addr_width;
				msg_len = MSG_FIXED_BYTES + aw + it.length;
				// length checks win over the frame size check
				if (is_wr && it.length == 9'd0) begin
					expect_byte(8'h00, 1'b1, STATUS_BAD_LEN);
					n_err_results++;
				end else if (!is_wr && int'(it.length) + RESP_HEADER_BYTES > FRAME_BYTES) begin
					expect_byte(8'h00, 1'b1, STATUS_BAD_LEN);
					n_err_results++;
				end else if (msg_len > FRAME_BYTES) begin
					expect_byte(8'h00, 1'b1, STATUS_TOO_LONG);
					n_err_results++;
				end else begin
					expect_byte(BYTE_STX, 1'b0, STATUS_OK);
					expect_byte(8'(msg_len >> 8), 1'b0, STATUS_OK);
					expect_byte(8'(msg_len), 1'b0, STATUS_OK);
					expect_byte(BYTE_FUNC, 1'b0, STATUS_OK);
					expect_byte(pred_dev_addr, 1'b0, STATUS_OK);
					expect_byte({5'd0, aw}, 1'b0, STATUS_OK);
					// offset, most significant byte first
					for (int i = aw; i > 0; i--)
						expect_byte(8'(it.offset >> (8 * (i - 1))), 1'b0, STATUS_OK);
					expect_byte(is_wr ? BYTE_WRITE : BYTE_READ, 1'b0, STATUS_OK);
					expect_byte({7'd0, it.length[8]}, 1'b0, STATUS_OK);
					// a write header ends its run here; data follows later
					expect_byte(it.length[7:0], is_wr, STATUS_OK);
					if (is_wr) begin
						pred_write_open = 1'b1;
						pred_bytes_left = it.length;
					end else begin
						expect_byte(BYTE_ETX, 1'b1, STATUS_OK);
					end
					n_frames++;
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result checking: each output transaction against the oldest prediction
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input int got, input int want);
		n_mismatch++;
		if (n_mismatch <= MAX_PRINTED)
			$display("%0t: %s differs: got 0x%0h, expected 0x%0h (result %0d)",
				$time, what, got, want, n_checked);
	endtask

	// Outputs are sampled at the edge, before the block updates them.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (frame_q.size() == 0) begin
				report_mismatch("unpredicted result, frame_byte", out_data.frame_byte, 0);
			end else begin
				want_res = frame_q.pop_front();
				if (out_data.frame_byte !== want_res.frame_byte)
					report_mismatch("frame_byte", out_data.frame_byte, want_res.frame_byte);
				if (out_data.last !== want_res.last)
					report_mismatch("last", out_data.last, want_res.last);
				if (out_data.status !== want_res.status)
					report_mismatch("status", out_data.status, want_res.status);
				n_checked++;
			end
		end
	end

	// Receiver backpressure: free-running, scattered single stalls, or long stall runs.
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      = rx_mode_e'($urandom_range(0, 2));
			rx_mode_left = $urandom_range(40, 300);
		end else begin
			rx_mode_left--;
		end
		case (rx_mode)
			RX_FREE: begin
				out_stall <= 1'b0;
			end
			RX_SCATTER: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				if (rx_run > 0) begin
					out_stall <= 1'b1;
					rx_run--;
				end else if ($urandom_range(0, 7) == 0) begin
					out_stall <= 1'b1;
					rx_run = $urandom_range(0, 19);
				end else begin
					out_stall <= 1'b0;
				end
			end
		endcase
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, frame_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Drives one transaction and holds it until accepted. Transactions go out in
	// bursts; a gap of idle cycles comes before each new burst.
	task automatic send_item(input in_item_t it);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_frame(it);
		burst_left--;
		if (it.command == CMD_NONE)
			n_ignored++;
		else
			n_items++;
	endtask

	task automatic send_cmd(input logic [1:0] cmd, input logic [8:0] len,
		input logic [31:0] off, input logic [7:0] data);
		in_item_t it;
		it.command   = cmd;
		it.length    = len;
		it.offset    = off;
		it.data_byte = data;
		send_item(it);
	endtask

	// All fields random except the command.
	function automatic in_item_t random_item(input logic [1:0] cmd);
		in_item_t it;
		it.command   = cmd;
		it.length    = 9'($urandom);
		it.offset    = $urandom;
		it.data_byte = 8'($urandom);
		return it;
	endfunction

	// Stop sending, then wait until every predicted byte has come out and the
	// block has had time to finish anything that produces no output.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (frame_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_DEVICE_ADDRESS)
			pred_dev_addr = value;
		else
			pred_addr_width = value[2:0];
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset values: address 0, one offset byte.
	task automatic test_reset_values();
		send_cmd(CMD_READ, 9'd3, 32'h1234_5678, 8'h00);
		// no write open yet: out of sequence
		send_cmd(CMD_DATA, 9'd0, 32'h0000_0000, 8'hA5);
		// unused code is swallowed
		send_cmd(CMD_NONE, 9'h1FF, 32'hFFFF_FFFF, 8'hFF);
	endtask

	// Field extremes and every length check at the widest offset.
	task automatic test_field_extremes();
		set_reg(REG_DEVICE_ADDRESS, 8'hFF);
		set_reg(REG_ADDR_WIDTH, 8'd4);
		send_cmd(CMD_READ, 9'd0, 32'hFFFF_FFFF, 8'h00);
		send_cmd(CMD_WRITE, 9'd1, 32'h0000_0000, 8'h00);
		send_cmd(CMD_DATA, 9'h1FF, 32'hFFFF_FFFF, 8'hFF);
		// largest write that fits, abandoned after two bytes by a read start
		send_cmd(CMD_WRITE, 9'd245, 32'h8000_0001, 8'h00);
		send_cmd(CMD_DATA, 9'd0, 32'h0000_0000, 8'h00);
		send_cmd(CMD_DATA, 9'd0, 32'h0000_0000, 8'h7F);
		send_cmd(CMD_READ, 9'd245, 32'h0102_0304, 8'h00);
		// one past the size limit, then the read length limit and beyond
		send_cmd(CMD_READ, 9'd246, 32'h0000_0000, 8'h00);
		send_cmd(CMD_READ, 9'd254, 32'h0000_0000, 8'h00);
		send_cmd(CMD_READ, 9'd255, 32'h0000_0000, 8'h00);
		send_cmd(CMD_READ, 9'h1FF, 32'h0000_0000, 8'h00);
		send_cmd(CMD_WRITE, 9'd0, 32'h0000_0000, 8'h00);
		send_cmd(CMD_WRITE, 9'h1FF, 32'h0000_0000, 8'h00);
		send_cmd(CMD_DATA, 9'd0, 32'h0000_0000, 8'h11);
	endtask

	// No offset bytes, then widths above the maximum.
	task automatic test_addr_width_range();
		set_reg(REG_DEVICE_ADDRESS, 8'h00);
		set_reg(REG_ADDR_WIDTH, 8'd0);
		send_cmd(CMD_WRITE, 9'd2, 32'hDEAD_BEEF, 8'h00);
		send_cmd(CMD_DATA, 9'd0, 32'h0000_0000, 8'h00);
		send_cmd(CMD_DATA, 9'd0, 32'h0000_0000, 8'h80);
		// fits exactly, then a failing start drops it
		send_cmd(CMD_WRITE, 9'd249, 32'h0000_0000, 8'h00);
		send_cmd(CMD_WRITE, 9'd250, 32'h0000_0000, 8'h00);
		send_cmd(CMD_DATA, 9'd0, 32'h0000_0000, 8'h22);
		set_reg(REG_ADDR_WIDTH, 8'd7);
		send_cmd(CMD_READ, 9'd1, 32'hCAFE_BABE, 8'h00);
		set_reg(REG_ADDR_WIDTH, 8'd5);
		send_cmd(CMD_READ, 9'd0, 32'h00FF_00FF, 8'h00);
	endtask

	// One long write frame carried through to its ETX.
	task automatic test_long_write();
		in_item_t it;
		set_reg(REG_DEVICE_ADDRESS, 8'h5A);
		set_reg(REG_ADDR_WIDTH, 8'd4);
		it = random_item(CMD_WRITE);
		it.length = 9'(LONG_WRITE_LEN);
		send_item(it);
		repeat (LONG_WRITE_LEN) send_item(random_item(CMD_DATA));
	endtask

	// Mostly complete write frames with random content, plus reads, cut-short
	// writes, stray data, random starts and plain noise.
	task automatic test_random_traffic();
		in_item_t    it;
		int unsigned start_items;
		int          since_cfg;
		int          kind;
		int          len;
		int          cut;
		start_items = n_items;
		since_cfg   = 0;
		while (n_items - start_items < RANDOM_ITEMS) begin
			// reconfigure only between frames
			if (since_cfg >= 60 && !pred_write_open) begin
				kind = $urandom_range(0, 3);
				set_reg(REG_DEVICE_ADDRESS, (kind == 0) ? 8'h00 : (kind == 1) ? 8'hFF
					: 8'($urandom));
				set_reg(REG_ADDR_WIDTH, 8'($urandom_range(0, 7)));
				since_cfg = 0;
			end
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 6);
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
				it = random_item(CMD_WRITE);
				it.length = 9'(len);
				send_item(it);
				repeat (cut) send_item(random_item(CMD_DATA));
				since_cfg += cut + 1;
			end else if (kind < 75) begin
				it = random_item(CMD_READ);
				it.length = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
					: 9'($urandom_range(0, 20));
				send_item(it);
				since_cfg++;
			end else if (kind < 87) begin
				send_item(random_item(2'($urandom_range(0, 3))));
				since_cfg++;
			end else if (kind < 94) begin
				send_item(random_item(CMD_DATA));
				since_cfg++;
			end else begin
				// any length: bad, too long, or a frame left open
				send_item(random_item(CMD_WRITE));
				since_cfg++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		pred_dev_addr   = 8'h00;
		pred_addr_width = ADDR_WIDTH_RESET;
		pred_write_open = 1'b0;
		pred_bytes_left = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_field_extremes();
		test_addr_width_range();
		test_long_write();
		test_random_traffic();
		wait_idle();

		$display("Sent %0d transactions plus %0d with the unused code: %0d frames, %0d error results",
			n_items, n_ignored, n_frames, n_err_results);
		$display("Compared %0d frame bytes over several address and offset width settings",
			n_checked);
		if (n_mismatch == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
